// ===== hw/rtl/ppp_pkg.sv =====
// Package for the pinhole point projection block.
// Widths, pipeline payload types and status/register codes; no dependencies.
package ppp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DVD_W       = COORD_WIDTH + FRAC_BITS;
  localparam int QUO_W       = DVD_W;
  localparam int QUO_H       = QUO_W / 2;
  localparam int PROD_W      = QUO_W + COORD_WIDTH;
  localparam int MAG_W       = PROD_W - FRAC_BITS;
  localparam int DIV_STAGES  = QUO_W;
  localparam int IDX_W       = 3;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_DEPTH = 2'd1,
    STATUS_SAT   = 2'd2
  } status_e;

  typedef enum logic [IDX_W-1:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_ORTHO    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] rem;
    logic [DVD_W-1:0]       dvd;
    logic [QUO_W-1:0]       quo;
    logic [COORD_WIDTH-1:0] mag;
    logic                   neg;
  } lane_t;

  typedef struct packed {
    lane_t                  x;
    lane_t                  y;
    logic [COORD_WIDTH-1:0] den;
    logic                   ortho;
    logic                   zbad;
  } div_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic             neg_x;
    logic             neg_y;
    logic             zbad;
  } mag_t;

endpackage

// ===== hw/rtl/ppp_if.sv =====
// Valid/ready channel interfaces for points in and pixels out.
// Depends on ppp_pkg for coordinate widths.
interface ppp_point_if import ppp_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_pixel_if import ppp_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pixel_u;
  logic signed [COORD_WIDTH-1:0] pixel_v;
  logic [1:0]                    status;
  modport source (output valid, pixel_u, pixel_v, status, input ready);
  modport sink   (input valid, pixel_u, pixel_v, status, output ready);
endinterface

// ===== hw/rtl/ppp_div_stage.sv =====
// One restoring-division stage: one quotient bit for each of the two lanes.
// Depends on ppp_pkg.
module ppp_div_stage import ppp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);

  logic valid_q;
  div_t data_d, data_q;

  function automatic lane_t step(lane_t l, logic [COORD_WIDTH-1:0] den);
    logic [COORD_WIDTH:0] t;
    logic                 ge;
    lane_t                r;
    t  = {l.rem, l.dvd[DVD_W-1]};
    ge = (t >= {1'b0, den});
    r  = l;
    r.rem = ge ? COORD_WIDTH'(t - {1'b0, den}) : t[COORD_WIDTH-1:0];
    r.dvd = {l.dvd[DVD_W-2:0], 1'b0};
    r.quo = {l.quo[QUO_W-2:0], ge};
    return r;
  endfunction

  always_comb begin
    data_d   = data_i;
    data_d.x = step(data_i.x, data_i.den);
    data_d.y = step(data_i.y, data_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/ppp_mul.sv =====
// Focal-length multiply: split partial products, then sum and drop fraction.
// Depends on ppp_pkg; two register stages.
module ppp_mul import ppp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  div_t                   data_i,
  input  logic [COORD_WIDTH-1:0] focal_x_i,
  input  logic [COORD_WIDTH-1:0] focal_y_i,
  output logic                   valid_o,
  output mag_t                   data_o
);

  localparam int PP_W = QUO_H + COORD_WIDTH;

  logic             va_q, vb_q;
  logic [QUO_W-1:0] ax, ay;
  logic [PP_W-1:0]  lx_q, hx_q, ly_q, hy_q;
  logic             nx_q, ny_q, zb_q;
  logic [PROD_W-1:0] px, py;
  mag_t             mag_d, mag_q;

  assign ax = data_i.ortho ? QUO_W'(data_i.x.mag) : data_i.x.quo;
  assign ay = data_i.ortho ? QUO_W'(data_i.y.mag) : data_i.y.quo;

  assign px = (PROD_W'(hx_q) << QUO_H) + PROD_W'(lx_q);
  assign py = (PROD_W'(hy_q) << QUO_H) + PROD_W'(ly_q);

  always_comb begin
    mag_d.mag_x = px[PROD_W-1:FRAC_BITS];
    mag_d.mag_y = py[PROD_W-1:FRAC_BITS];
    mag_d.neg_x = nx_q;
    mag_d.neg_y = ny_q;
    mag_d.zbad  = zb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lx_q  <= PP_W'(ax[QUO_H-1:0] * focal_x_i);
      hx_q  <= PP_W'(ax[QUO_W-1:QUO_H] * focal_x_i);
      ly_q  <= PP_W'(ay[QUO_H-1:0] * focal_y_i);
      hy_q  <= PP_W'(ay[QUO_W-1:QUO_H] * focal_y_i);
      nx_q  <= data_i.x.neg;
      ny_q  <= data_i.y.neg;
      zb_q  <= data_i.zbad;
      mag_q <= mag_d;
    end
  end

  assign valid_o = vb_q;
  assign data_o  = mag_q;

endmodule

// ===== hw/rtl/ppp_finish.sv =====
// Sign, center offset and saturation; holds the output register.
// Depends on ppp_pkg.
module ppp_finish import ppp_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  mag_t                          data_i,
  input  logic signed [COORD_WIDTH-1:0] center_x_i,
  input  logic signed [COORD_WIDTH-1:0] center_y_i,
  output logic                          valid_o,
  output logic signed [COORD_WIDTH-1:0] pixel_u_o,
  output logic signed [COORD_WIDTH-1:0] pixel_v_o,
  output status_e                       status_o
);

  typedef struct packed {
    logic                   sat;
    logic [COORD_WIDTH-1:0] val;
  } res_t;

  localparam logic [COORD_WIDTH-1:0] TOP = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] BOT = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  function automatic res_t fin(logic neg, logic [MAG_W-1:0] mag,
                               logic [COORD_WIDTH-1:0] c);
    logic signed [COORD_WIDTH+1:0] sm, s;
    res_t r;
    sm = $signed({2'b00, mag[COORD_WIDTH-1:0]});
    s  = (neg ? -sm : sm) + $signed({{2{c[COORD_WIDTH-1]}}, c});
    if (|mag[MAG_W-1:COORD_WIDTH]) begin
      r.sat = 1'b1;
      r.val = neg ? BOT : TOP;
    end else if (s[COORD_WIDTH+1] == 1'b0 && |s[COORD_WIDTH:COORD_WIDTH-1]) begin
      r.sat = 1'b1;
      r.val = TOP;
    end else if (s[COORD_WIDTH+1] == 1'b1 && !(&s[COORD_WIDTH:COORD_WIDTH-1])) begin
      r.sat = 1'b1;
      r.val = BOT;
    end else begin
      r.sat = 1'b0;
      r.val = s[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  res_t    ru, rv;
  logic    valid_q;
  logic [COORD_WIDTH-1:0] u_d, v_d, u_q, v_q;
  status_e st_d, st_q;

  always_comb begin
    ru = fin(data_i.neg_x, data_i.mag_x, center_x_i);
    rv = fin(data_i.neg_y, data_i.mag_y, center_y_i);
    if (data_i.zbad) begin
      u_d  = '0;
      v_d  = '0;
      st_d = STATUS_DEPTH;
    end else begin
      u_d  = ru.val;
      v_d  = rv.val;
      st_d = (ru.sat || rv.sat) ? STATUS_SAT : STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q  <= u_d;
      v_q  <= v_d;
      st_q <= st_d;
    end
  end

  assign valid_o   = valid_q;
  assign pixel_u_o = $signed(u_q);
  assign pixel_v_o = $signed(v_q);
  assign status_o  = st_q;

endmodule

// ===== hw/rtl/pinhole_point_projection_top.sv =====
// Top level of the pinhole point projection pipeline.
// Depends on ppp_pkg, ppp_if, ppp_div_stage, ppp_mul and ppp_finish.
// Accepts one point per cycle while the output is not stalled and returns one pixel per
// point, in order, through one input stage, one divider stage per quotient bit (48), two
// multiply stages and the output register. Any output stall freezes the whole pipeline.
module pinhole_point_projection_top import ppp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [IDX_W-1:0]       cfg_idx_i,
  input  logic [COORD_WIDTH-1:0] cfg_data_i,
  ppp_point_if.sink              in_if,
  ppp_pixel_if.source            out_if
);

  logic [COORD_WIDTH-1:0] fx_q, fy_q, cx_q, cy_q;
  logic                   ortho_q;
  logic                   en;
  logic                   v0_q;
  div_t                   d0_d, d0_q;
  logic                   dv [DIV_STAGES+1];
  div_t                   dd [DIV_STAGES+1];
  logic                   mv;
  mag_t                   md;
  logic                   fv;
  status_e                st;

  assign en          = !fv || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q    <= COORD_WIDTH'(1) << FRAC_BITS;
      fy_q    <= COORD_WIDTH'(1) << FRAC_BITS;
      cx_q    <= '0;
      cy_q    <= '0;
      ortho_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FOCAL_X:  fx_q    <= cfg_data_i;
        REG_FOCAL_Y:  fy_q    <= cfg_data_i;
        REG_CENTER_X: cx_q    <= cfg_data_i;
        REG_CENTER_Y: cy_q    <= cfg_data_i;
        REG_ORTHO:    ortho_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  function automatic lane_t seed(logic [COORD_WIDTH-1:0] v);
    lane_t l;
    l.neg = v[COORD_WIDTH-1];
    l.mag = l.neg ? COORD_WIDTH'(~v + 1'b1) : v;
    l.rem = '0;
    l.dvd = {l.mag, {FRAC_BITS{1'b0}}};
    l.quo = '0;
    return l;
  endfunction

  always_comb begin
    d0_d.x     = seed(in_if.point_x);
    d0_d.y     = seed(in_if.point_y);
    d0_d.den   = in_if.point_z;
    d0_d.ortho = ortho_q;
    d0_d.zbad  = !ortho_q && (in_if.point_z[COORD_WIDTH-1] || in_if.point_z == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_q <= d0_d;
    end
  end

  assign dv[0] = v0_q;
  assign dd[0] = d0_q;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    ppp_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[g]),
      .data_i  (dd[g]),
      .valid_o (dv[g+1]),
      .data_o  (dd[g+1])
    );
  end

  ppp_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (dv[DIV_STAGES]),
    .data_i    (dd[DIV_STAGES]),
    .focal_x_i (fx_q),
    .focal_y_i (fy_q),
    .valid_o   (mv),
    .data_o    (md)
  );

  ppp_finish u_finish (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (mv),
    .data_i     (md),
    .center_x_i ($signed(cx_q)),
    .center_y_i ($signed(cy_q)),
    .valid_o    (fv),
    .pixel_u_o  (out_if.pixel_u),
    .pixel_v_o  (out_if.pixel_v),
    .status_o   (st)
  );

  assign out_if.valid  = fv;
  assign out_if.status = st;

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the pinhole point projection pipeline: drives points, predicts pixels,
// checks every pixel in order against a projection scoreboard.
// Depends on ppp_pkg, ppp_if and pinhole_point_projection_top.
module tb_top;
  import ppp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t  u;
    coord_t  v;
    status_e st;
  } pixel_t;

  class projection_sb;
    coord_t        fx, fy, cx, cy;
    logic          ortho;
    pixel_t        pending[$];
    int            errors;

    function new();
      fx = coord_t'(1) << FRAC_BITS;
      fy = coord_t'(1) << FRAC_BITS;
      cx = '0;
      cy = '0;
      ortho = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, coord_t data);
      case (idx)
        REG_FOCAL_X:  fx = data;
        REG_FOCAL_Y:  fy = data;
        REG_CENTER_X: cx = data;
        REG_CENTER_Y: cy = data;
        REG_ORTHO:    ortho = data[0];
        default: ;
      endcase
    endfunction

    function coord_t lane(coord_t c, coord_t z, coord_t f, coord_t ctr, ref bit sat);
      logic signed [63:0]  sc;
      logic [127:0]        m, p, mag;
      logic signed [127:0] s, top, bot;
      bit                  neg;
      sc  = 64'($signed(c));
      neg = c[COORD_WIDTH-1];
      m   = neg ? 128'(-sc) : 128'(sc);
      top = (128'sd1 <<< (COORD_WIDTH-1)) - 1;
      bot = -top - 1;
      if (ortho) p = m * 128'(f);
      else p = ((m << FRAC_BITS) / 128'(z)) * 128'(f);
      mag = p >> FRAC_BITS;
      if (mag >= (128'd1 << 62)) begin
        sat = 1;
        s = neg ? bot : top;
      end else begin
        s = (neg ? -$signed(mag) : $signed(mag)) + 128'($signed(ctr));
        if (s > top) begin
          s = top;
          sat = 1;
        end
        if (s < bot) begin
          s = bot;
          sat = 1;
        end
      end
      return s[COORD_WIDTH-1:0];
    endfunction

    function void note_point(coord_t x, coord_t y, coord_t z);
      pixel_t e;
      bit     sat;
      sat = 0;
      if (!ortho && $signed(z) <= 0) begin
        e.u = '0;
        e.v = '0;
        e.st = STATUS_DEPTH;
      end else begin
        e.u = lane(x, ortho ? coord_t'(1) : z, fx, cx, sat);
        e.v = lane(y, ortho ? coord_t'(1) : z, fy, cy, sat);
        e.st = sat ? STATUS_SAT : STATUS_OK;
      end
      pending.insert(pending.size(), e);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_pixel(coord_t u, coord_t v, logic [1:0] st);
      pixel_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected pixel u=%h v=%h st=%0d", u, v, st));
        return;
      end
      e = pending.pop_front();
      if (u !== e.u) report($sformatf("pixel_u %h, want %h", u, e.u));
      if (v !== e.v) report($sformatf("pixel_v %h, want %h", v, e.v));
      if (st !== e.st) report($sformatf("status %0d, want %0d", st, e.st));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  coord_t cfg_data_i = '0;

  ppp_point_if in_if ();
  ppp_pixel_if out_if ();

  pinhole_point_projection_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  projection_sb sb = new();
  bit quiet = 0;
  bit hold_req = 0;
  bit sent_all = 0;

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.point_z = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      sb.note_point(in_if.point_x, in_if.point_y, in_if.point_z);
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_pixel(out_if.pixel_u, out_if.pixel_v, out_if.status);
  end

  initial begin : pixel_sink
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 0;
      end
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        out_if.ready = 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 5))
      0, 1: return coord_t'($urandom());
      2, 3: return coord_t'($signed($urandom_range(0, 2 ** 22)) - (2 ** 21));
      4: return coord_t'($signed($urandom_range(0, 2 ** 12)) - (2 ** 11));
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  function automatic coord_t pick_depth();
    case ($urandom_range(0, 9))
      0: return coord_t'($urandom());
      1: return coord_t'(-$signed($urandom_range(0, 2 ** 20)));
      2: return $urandom_range(1, 3);
      default: return $urandom_range(2 ** 12, 2 ** 24);
    endcase
  endfunction

  task automatic send_point(coord_t x, coord_t y, coord_t z);
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 16);
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.point_x = x;
    in_if.point_y = y;
    in_if.point_z = z;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, coord_t data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic write_all(coord_t fx, coord_t fy, coord_t cx, coord_t cy, logic mode);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_ORTHO, coord_t'(mode));
  endtask

  initial begin : stimulus
    coord_t fx, fy, cx, cy;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_point(32'h0001_0000, 32'hffff_0000, 32'h0001_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h0003_0000, 32'h0005_0000, 32'h0000_0000);
    send_point(32'h0003_0000, 32'h0005_0000, 32'h8000_0000);
    send_point(32'h0003_0000, 32'h0005_0000, 32'hffff_ffff);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0002_0000);
    send_point(32'hffff_ffff, 32'h0000_0001, 32'h0000_3000);
    drain();

    write_reg(cfg_idx_e'(5), 32'h1234_5678);
    write_reg(cfg_idx_e'(7), 32'hffff_ffff);
    write_all(32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_point(32'hffff_0000, 32'hffff_0000, 32'h0000_0001);
    send_point(32'h0000_0001, 32'h0000_0001, 32'h7fff_ffff);
    drain();
    write_all(32'hffff_ffff, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_point(32'h0000_0001, 32'hffff_ffff, 32'h0001_0000);
    send_point(32'h0000_0000, 32'h0000_0000, 32'hffff_ffff);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin
          fx = $urandom_range(2 ** 16, 2 ** 26);
          fy = $urandom_range(2 ** 16, 2 ** 26);
        end
        1: begin
          fx = $urandom();
          fy = $urandom();
        end
        2: begin
          fx = $urandom_range(0, 2 ** 17);
          fy = $urandom_range(0, 2 ** 17);
        end
        default: begin
          fx = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
          fy = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0001_0000;
        end
      endcase
      cx = (ph % 3 == 0) ? coord_t'($urandom()) : coord_t'($urandom_range(0, 2 ** 26));
      cy = (ph % 3 == 0) ? coord_t'($urandom()) : coord_t'(-$urandom_range(0, 2 ** 26));
      write_all(fx, fy, cx, cy, logic'(ph % 2));
      if (ph == 10) quiet = 1;
      for (int i = 0; i < 85; i++) begin
        if (ph == 3 && i == 5) hold_req = 1;
        send_point(pick_coord(), pick_coord(), pick_depth());
      end
      drain();
    end
    sent_all = 1;
  end

  initial begin : finish_check
    wait (sent_all);
    @(negedge clk_i);
    while (in_if.valid || sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
